>>> hw/rtl/tdrt_pkg.sv
// Package for the transmit descriptor ring tracker: beat types, codes and defaults.
// Used by tx_descriptor_ring_tracker_core; depends on nothing else.
`default_nettype none

package tdrt_pkg;

   // Ring size default and register reset value
   localparam int unsigned RING_ENTRIES_DEFAULT = 8;
   localparam logic [15:0] TIMEOUT_RESET        = 16'd20;
   localparam int unsigned NUM_COUNTERS         = 9;

   // Actions carried by an input beat
   typedef enum logic [1:0] {
      ACT_SUBMIT   = 2'd0,
      ACT_COMPLETE = 2'd1,
      ACT_RECLAIM  = 2'd2,
      ACT_TICK     = 2'd3
   } action_type;

   // Status codes of a result beat
   localparam logic [2:0] ST_ACCEPTED  = 3'd0;
   localparam logic [2:0] ST_BUSY      = 3'd1;
   localparam logic [2:0] ST_RING_FULL = 3'd2;
   localparam logic [2:0] ST_TIMED_OUT = 3'd3;
   localparam logic [2:0] ST_DONE      = 3'd4;

   // Statistics counter indexes
   localparam logic [3:0] C_PACKETS    = 4'd0;
   localparam logic [3:0] C_BYTES      = 4'd1;
   localparam logic [3:0] C_ERRORS     = 4'd2;
   localparam logic [3:0] C_HEARTBEAT  = 4'd3;
   localparam logic [3:0] C_WINDOW     = 4'd4;
   localparam logic [3:0] C_ABORTED    = 4'd5;
   localparam logic [3:0] C_FIFO       = 4'd6;
   localparam logic [3:0] C_CARRIER    = 4'd7;
   localparam logic [3:0] C_COLLISIONS = 4'd8;

   // Sequencer states
   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_EXEC,
      SEQ_CHECK,
      SEQ_READ,
      SEQ_FINISH
   } seq_state_type;

   // Input beat
   typedef struct packed {
      logic [1:0]  action;
      logic [10:0] frame_length;
      logic        heartbeat_lost;
      logic        late_collision;
      logic        retry_limit;
      logic        underrun;
      logic        carrier_lost;
      logic        deferred;
      logic [3:0]  counter_select;
   } req_type;

   // Result beat
   typedef struct packed {
      logic [2:0]  status;
      logic [3:0]  reclaimed_count;
      logic        ring_full;
      logic        transmitter_busy;
      logic [3:0]  in_flight;
      logic [31:0] counter_value;
   } rsp_type;

endpackage

`default_nettype wire

>>> hw/rtl/tx_descriptor_ring_tracker_core.sv
// Top level of the transmit descriptor ring tracker: sequencer, slot flag memory,
// ready bits and statistics counters. Depends on tdrt_pkg.
`default_nettype none

// Tracks a transmit descriptor ring of RING_ENTRIES slots. Each request beat
// (submit, completion, reclaim or tick) produces exactly one response beat with
// the status, the ring flags, the occupancy and one selected statistics counter.
// Submit, completion and tick pass through the EXEC and FINISH states; a reclaim
// also passes through CHECK and through READ once per freed slot, because each
// slot's completion flags are read from a synchronous flag memory into a
// register before the counters are updated. A new request is
// accepted while the previous response still waits in the output register;
// while that response is not taken, the sequencer holds in its last step.
// No clearing pass is needed after reset.
module tx_descriptor_ring_tracker_core #(
   parameter int unsigned RING_ENTRIES = tdrt_pkg::RING_ENTRIES_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire tdrt_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output tdrt_pkg::rsp_type     rsp_data,
   input  wire logic             csr_write_enable,
   input  wire logic [15:0]      csr_write_data
);
   import tdrt_pkg::*;

   localparam int unsigned IDX_W = (RING_ENTRIES > 1) ? $clog2(RING_ENTRIES) : 1;
   localparam int unsigned CNT_W = $clog2(RING_ENTRIES + 1);

   // Registers
   seq_state_type            state_ff, state_in;
   req_type                  item_ff, item_in;
   logic [15:0]              timeout_ff, timeout_in;
   logic [RING_ENTRIES-1:0]  ready_ff, ready_in;
   logic [IDX_W-1:0]         submit_idx_ff, submit_idx_in;
   logic [IDX_W-1:0]         reclaim_idx_ff, reclaim_idx_in;
   logic [IDX_W-1:0]         hw_idx_ff, hw_idx_in;
   logic                     full_ff, full_in;
   logic                     busy_ff, busy_in;
   logic [15:0]              ticks_ff, ticks_in;
   logic [31:0]              stat_ff [NUM_COUNTERS];
   logic [31:0]              stat_in [NUM_COUNTERS];
   logic [2:0]               status_ff, status_in;
   logic [CNT_W-1:0]         walk_ff, walk_in;
   logic [CNT_W-1:0]         limit_ff, limit_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_ff, rsp_in;

   // Slot flag memory
   logic [5:0]               flags_mem [RING_ENTRIES];
   logic [5:0]               flags_rd_ff;
   logic                     mem_we;
   logic                     mem_re;

   // Helpers
   logic                     accept;
   logic                     walk_go;
   logic                     rsp_load;
   logic [CNT_W-1:0]         occupied;
   logic [IDX_W-1:0]         submit_next;
   logic [IDX_W-1:0]         reclaim_next;
   logic [IDX_W-1:0]         hw_next;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == SEQ_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign rsp_load  = (state_ff == SEQ_FINISH) && (!rsp_valid_ff || rsp_ready);

   // Ring arithmetic
   assign submit_next  = (submit_idx_ff == IDX_W'(RING_ENTRIES - 1)) ? '0
                                                                    : submit_idx_ff + 1'b1;
   assign reclaim_next = (reclaim_idx_ff == IDX_W'(RING_ENTRIES - 1)) ? '0
                                                                     : reclaim_idx_ff + 1'b1;
   assign hw_next      = (hw_idx_ff == IDX_W'(RING_ENTRIES - 1)) ? '0 : hw_idx_ff + 1'b1;

   always_comb begin
      if (full_ff) begin
         occupied = CNT_W'(RING_ENTRIES);
      end else if (submit_idx_ff >= reclaim_idx_ff) begin
         occupied = CNT_W'(submit_idx_ff) - CNT_W'(reclaim_idx_ff);
      end else begin
         occupied = CNT_W'(submit_idx_ff) + CNT_W'(RING_ENTRIES) - CNT_W'(reclaim_idx_ff);
      end
   end

   // The walk continues while slots remain and the next one has been closed
   assign walk_go = (walk_ff < limit_ff) && !ready_ff[reclaim_idx_ff];

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         SEQ_IDLE: begin
            if (accept) state_in = SEQ_EXEC;
         end
         SEQ_EXEC: begin
            if (action_type'(item_ff.action) == ACT_RECLAIM) state_in = SEQ_CHECK;
            else state_in = SEQ_FINISH;
         end
         SEQ_CHECK: begin
            if (walk_go) state_in = SEQ_READ;
            else state_in = SEQ_FINISH;
         end
         SEQ_READ: begin
            state_in = SEQ_CHECK;
         end
         SEQ_FINISH: begin
            if (rsp_load) state_in = SEQ_IDLE;
         end
         default: state_in = SEQ_IDLE;
      endcase
   end

   // Datapath and outputs of the sequencer
   always_comb begin
      item_in        = item_ff;
      timeout_in     = timeout_ff;
      ready_in       = ready_ff;
      submit_idx_in  = submit_idx_ff;
      reclaim_idx_in = reclaim_idx_ff;
      hw_idx_in      = hw_idx_ff;
      full_in        = full_ff;
      busy_in        = busy_ff;
      ticks_in       = ticks_ff;
      stat_in        = stat_ff;
      status_in      = status_ff;
      walk_in        = walk_ff;
      limit_in       = limit_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_in         = rsp_ff;
      mem_we         = 1'b0;
      mem_re         = 1'b0;

      if (csr_write_enable) timeout_in = csr_write_data;

      unique case (state_ff)
         SEQ_IDLE: begin
            if (accept) item_in = req_data;
         end
         SEQ_EXEC: begin
            walk_in = '0;
            case (action_type'(item_ff.action))
               ACT_SUBMIT: begin
                  if (busy_ff) begin
                     if (ticks_ff < timeout_ff) begin
                        status_in = ST_BUSY;
                     end else begin
                        stat_in[C_ERRORS] = stat_ff[C_ERRORS] + 32'd1;
                        busy_in   = 1'b0;
                        ticks_in  = '0;
                        status_in = ST_TIMED_OUT;
                     end
                  end else if (full_ff || ready_ff[submit_idx_ff]) begin
                     busy_in   = 1'b1;
                     status_in = ST_RING_FULL;
                  end else begin
                     ready_in[submit_idx_ff] = 1'b1;
                     stat_in[C_BYTES] = stat_ff[C_BYTES] + 32'(item_ff.frame_length);
                     ticks_in      = '0;
                     submit_idx_in = submit_next;
                     if (submit_next == reclaim_idx_ff) begin
                        full_in = 1'b1;
                        busy_in = 1'b1;
                     end else begin
                        busy_in = 1'b0;
                     end
                     status_in = ST_ACCEPTED;
                  end
               end
               ACT_COMPLETE: begin
                  if (ready_ff[hw_idx_ff]) begin
                     ready_in[hw_idx_ff] = 1'b0;
                     mem_we    = 1'b1;
                     hw_idx_in = hw_next;
                     status_in = ST_ACCEPTED;
                  end else begin
                     status_in = ST_DONE;
                  end
               end
               ACT_RECLAIM: begin
                  limit_in  = occupied;
                  status_in = ST_DONE;
               end
               default: begin
                  if (ticks_ff != 16'hFFFF) ticks_in = ticks_ff + 16'd1;
                  status_in = ST_ACCEPTED;
               end
            endcase
         end
         SEQ_CHECK: begin
            if (walk_go) begin
               mem_re = 1'b1;
            end else if (walk_ff != '0) begin
               full_in = 1'b0;
               busy_in = 1'b0;
            end
         end
         SEQ_READ: begin
            // Count one closed slot from its stored completion flags
            stat_in[C_HEARTBEAT]  = stat_ff[C_HEARTBEAT]  + 32'(flags_rd_ff[0]);
            stat_in[C_WINDOW]     = stat_ff[C_WINDOW]     + 32'(flags_rd_ff[1]);
            stat_in[C_ABORTED]    = stat_ff[C_ABORTED]    + 32'(flags_rd_ff[2]);
            stat_in[C_FIFO]       = stat_ff[C_FIFO]       + 32'(flags_rd_ff[3]);
            stat_in[C_CARRIER]    = stat_ff[C_CARRIER]    + 32'(flags_rd_ff[4]);
            stat_in[C_ERRORS]     = stat_ff[C_ERRORS]     + 32'(|flags_rd_ff[4:0]);
            stat_in[C_PACKETS]    = stat_ff[C_PACKETS]    + 32'd1;
            stat_in[C_COLLISIONS] = stat_ff[C_COLLISIONS] + 32'(flags_rd_ff[5]);
            reclaim_idx_in = reclaim_next;
            walk_in        = walk_ff + 1'b1;
         end
         SEQ_FINISH: begin
            if (rsp_load) begin
               rsp_valid_in           = 1'b1;
               rsp_in.status          = status_ff;
               rsp_in.reclaimed_count = (action_type'(item_ff.action) == ACT_RECLAIM)
                                        ? 4'(walk_ff) : 4'd0;
               rsp_in.ring_full        = full_ff;
               rsp_in.transmitter_busy = busy_ff;
               rsp_in.in_flight        = 4'(occupied);
               rsp_in.counter_value    = (item_ff.counter_select < 4'(NUM_COUNTERS))
                                         ? stat_ff[item_ff.counter_select] : 32'd0;
            end
         end
         default: begin
         end
      endcase

      // A waiting response leaves when taken, unless replaced in the same cycle
      if (rsp_valid_ff && rsp_ready && !rsp_load) rsp_valid_in = 1'b0;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= SEQ_IDLE;
         timeout_ff     <= TIMEOUT_RESET;
         ready_ff       <= '0;
         submit_idx_ff  <= '0;
         reclaim_idx_ff <= '0;
         hw_idx_ff      <= '0;
         full_ff        <= 1'b0;
         busy_ff        <= 1'b0;
         ticks_ff       <= '0;
         walk_ff        <= '0;
         limit_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
         for (int i = 0; i < NUM_COUNTERS; i++) stat_ff[i] <= '0;
      end else begin
         state_ff       <= state_in;
         timeout_ff     <= timeout_in;
         ready_ff       <= ready_in;
         submit_idx_ff  <= submit_idx_in;
         reclaim_idx_ff <= reclaim_idx_in;
         hw_idx_ff      <= hw_idx_in;
         full_ff        <= full_in;
         busy_ff        <= busy_in;
         ticks_ff       <= ticks_in;
         walk_ff        <= walk_in;
         limit_ff       <= limit_in;
         rsp_valid_ff   <= rsp_valid_in;
         stat_ff        <= stat_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      item_ff   <= item_in;
      status_ff <= status_in;
      rsp_ff    <= rsp_in;
   end

   // Slot flag memory: written on a completion, read during the reclaim walk
   always_ff @(posedge clock) begin
      if (mem_we) begin
         flags_mem[hw_idx_ff] <= {item_ff.deferred, item_ff.carrier_lost, item_ff.underrun,
                                  item_ff.retry_limit, item_ff.late_collision,
                                  item_ff.heartbeat_lost};
      end
      if (mem_re) flags_rd_ff <= flags_mem[reclaim_idx_ff];
   end

   // Outside a reclaim walk, a full ring has its submit and reclaim pointers together
   assert property (@(posedge clock) disable iff (reset)
      (full_ff && (walk_ff == '0)) |-> (submit_idx_ff == reclaim_idx_ff))
      else $error("ring full with submit and reclaim pointers apart");

   // The walk only reads slots that the transmitter has closed
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == SEQ_READ) |-> !ready_ff[reclaim_idx_ff])
      else $error("reclaim walk reads a slot still owned by the transmitter");

   // The walk never frees more slots than were in flight at its start
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == SEQ_CHECK || state_ff == SEQ_READ) |-> (walk_ff <= limit_ff))
      else $error("reclaim walk overran the in-flight count");

   // An accepted beat always starts execution on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == SEQ_EXEC))
      else $error("accepted beat not executed");

endmodule

`default_nettype wire

>>> bench/tx_descriptor_ring_tracker_core_tb.sv
// Self-checking testbench for tx_descriptor_ring_tracker_core: a directed table and then
// random phases, each checked beat by beat against a predictor or a hand-typed response.
// Depends on tdrt_pkg and tx_descriptor_ring_tracker_core only.
module tx_descriptor_ring_tracker_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tdrt_pkg::*;

   localparam int unsigned RING        = RING_ENTRIES_DEFAULT;
   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned HOLD_CYCLES = 600;

   // One row of the directed table. The row may carry a timeout write made before
   // its beat, and may carry a response typed in by hand.
   typedef struct {
      bit          csr_write;
      logic [15:0] csr_value;
      req_type     beat;
      bit          typed;
      rsp_type     typed_rsp;
   } stim_row_type;

   logic        clock            = 1'b0;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic        req_ready;
   req_type     req_data         = '0;
   logic        rsp_valid;
   logic        rsp_ready        = 1'b0;
   rsp_type     rsp_data;
   logic        csr_write_enable = 1'b0;
   logic [15:0] csr_write_data   = '0;

   // Predictor state: a private copy of the ring, its flags and the statistics.
   logic        desc_owned [RING];
   logic [5:0]  desc_flags [RING];
   int unsigned head_idx;
   int unsigned tail_idx;
   int unsigned hw_idx;
   logic        ring_full_q;
   logic        tx_busy_q;
   logic [15:0] ticks_q;
   logic [15:0] timeout_setting;
   logic [31:0] stats [NUM_COUNTERS];

   rsp_type      pending_responses [$];
   stim_row_type directed_rows [$];

   int unsigned mismatches     = 0;
   int unsigned beats_sent     = 0;
   int unsigned beats_checked  = 0;
   int unsigned settings_used  = 0;
   int unsigned timeouts_seen  = 0;
   int unsigned refusals_seen  = 0;
   int unsigned full_reclaims  = 0;
   int unsigned cycle_count    = 0;
   int unsigned rx_cycles      = 0;
   int unsigned hold_left      = 0;
   bit          long_hold_done = 1'b0;

   tx_descriptor_ring_tracker_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // Clock with a 4 ns period.
   always #2 clock = ~clock;

   // Watchdog on the total length of the run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tx_descriptor_ring_tracker_core regression: fail");
         $finish;
      end
   end

   // Slots that have been submitted and not yet reclaimed.
   function automatic int unsigned ring_fill();
      return ring_full_q ? RING : (head_idx + RING - tail_idx) % RING;
   endfunction

   // Works out the response to one request beat and advances the predicted state.
   function automatic rsp_type predict_ring_response(req_type beat);
      rsp_type     r;
      logic [5:0]  flags;
      int unsigned limit;
      int unsigned walked;
      r      = '0;
      walked = 0;
      flags  = {beat.deferred, beat.carrier_lost, beat.underrun,
                beat.retry_limit, beat.late_collision, beat.heartbeat_lost};
      case (action_type'(beat.action))
         ACT_SUBMIT: begin
            if (tx_busy_q) begin
               // A busy transmitter either asks for a retry or declares a timeout.
               if (ticks_q < timeout_setting) begin
                  r.status = ST_BUSY;
               end else begin
                  stats[C_ERRORS]++;
                  tx_busy_q = 1'b0;
                  ticks_q   = '0;
                  r.status  = ST_TIMED_OUT;
               end
            end else if (ring_full_q || desc_owned[head_idx]) begin
               tx_busy_q = 1'b1;
               r.status  = ST_RING_FULL;
            end else begin
               desc_flags[head_idx] = '0;
               desc_owned[head_idx] = 1'b1;
               stats[C_BYTES]       += 32'(beat.frame_length);
               ticks_q              = '0;
               head_idx             = (head_idx + 1) % RING;
               if (head_idx == tail_idx) begin
                  ring_full_q = 1'b1;
                  tx_busy_q   = 1'b1;
               end else begin
                  tx_busy_q = 1'b0;
               end
               r.status = ST_ACCEPTED;
            end
         end
         ACT_COMPLETE: begin
            // The transmitter closes slots strictly in order.
            if (!desc_owned[hw_idx]) begin
               r.status = ST_DONE;
            end else begin
               desc_owned[hw_idx] = 1'b0;
               desc_flags[hw_idx] = flags;
               hw_idx             = (hw_idx + 1) % RING;
               r.status           = ST_ACCEPTED;
            end
         end
         ACT_RECLAIM: begin
            // Walk closed slots from the tail, stopping at the first one still owned.
            limit = ring_fill();
            while (walked < limit && !desc_owned[tail_idx]) begin
               if (desc_flags[tail_idx][0]) stats[C_HEARTBEAT]++;
               if (desc_flags[tail_idx][1]) stats[C_WINDOW]++;
               if (desc_flags[tail_idx][2]) stats[C_ABORTED]++;
               if (desc_flags[tail_idx][3]) stats[C_FIFO]++;
               if (desc_flags[tail_idx][4]) stats[C_CARRIER]++;
               if (desc_flags[tail_idx][4:0] != '0) stats[C_ERRORS]++;
               stats[C_PACKETS]++;
               if (desc_flags[tail_idx][5]) stats[C_COLLISIONS]++;
               tail_idx = (tail_idx + 1) % RING;
               walked++;
            end
            if (walked > 0) begin
               ring_full_q = 1'b0;
               tx_busy_q   = 1'b0;
            end
            r.status = ST_DONE;
         end
         default: begin
            if (ticks_q != 16'hFFFF) ticks_q++;
            r.status = ST_ACCEPTED;
         end
      endcase
      r.reclaimed_count  = walked[3:0];
      r.ring_full        = ring_full_q;
      r.transmitter_busy = tx_busy_q;
      r.in_flight        = 4'(ring_fill());
      r.counter_value    = (beat.counter_select < NUM_COUNTERS) ?
                           stats[beat.counter_select] : 32'd0;
      return r;
   endfunction

   function automatic req_type make_beat(action_type act, logic [10:0] len,
                                         logic [5:0] flags, logic [3:0] sel);
      req_type b;
      b.action         = act;
      b.frame_length   = len;
      b.heartbeat_lost = flags[0];
      b.late_collision = flags[1];
      b.retry_limit    = flags[2];
      b.underrun       = flags[3];
      b.carrier_lost   = flags[4];
      b.deferred       = flags[5];
      b.counter_select = sel;
      return b;
   endfunction

   function automatic rsp_type make_rsp(logic [2:0] status, logic [3:0] freed,
                                        logic full, logic busy, logic [3:0] fill,
                                        logic [31:0] value);
      rsp_type r;
      r.status           = status;
      r.reclaimed_count  = freed;
      r.ring_full        = full;
      r.transmitter_busy = busy;
      r.in_flight        = fill;
      r.counter_value    = value;
      return r;
   endfunction

   task automatic add_row(input bit csr_write, input logic [15:0] csr_value,
                          input req_type beat, input bit typed, input rsp_type typed_rsp);
      stim_row_type row;
      row.csr_write = csr_write;
      row.csr_value = csr_value;
      row.beat      = beat;
      row.typed     = typed;
      row.typed_rsp = typed_rsp;
      directed_rows.push_back(row);
   endtask

   // Offers one request beat, holds it until accepted, then records the expectation.
   task automatic send_beat(input req_type beat, input bit typed, input rsp_type typed_rsp);
      rsp_type predicted;
      req_valid <= 1'b1;
      req_data  <= beat;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = predict_ring_response(beat);
      pending_responses.push_back(typed ? typed_rsp : predicted);
      beats_sent++;
      if (predicted.status == ST_TIMED_OUT) timeouts_seen++;
      if (predicted.status == ST_RING_FULL) refusals_seen++;
      if (predicted.reclaimed_count == 4'(RING)) full_reclaims++;
   endtask

   task automatic idle_cycles(input int unsigned n);
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // Stops offering beats until every expected response has come back.
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_responses.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Writes the timeout register; the block must be idle.
   task automatic write_timeout(input logic [15:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      timeout_setting  = value;
      settings_used++;
   endtask

   // A random phase: mostly submits and completions so the ring fills, wraps and
   // times out, with reclaims and ticks mixed in.
   task automatic random_phase(input int unsigned items, input bit bursty);
      req_type     beat;
      int unsigned left;
      int unsigned burst;
      int unsigned pick;
      left = items;
      while (left > 0) begin
         burst = bursty ? $urandom_range(1, 16) : left;
         while (burst > 0 && left > 0) begin
            pick = $urandom_range(0, 99);
            beat.action = (pick < 38) ? ACT_SUBMIT :
                          (pick < 68) ? ACT_COMPLETE :
                          (pick < 82) ? ACT_RECLAIM : ACT_TICK;
            case ($urandom_range(0, 3))
               0:       beat.frame_length = '0;
               1:       beat.frame_length = '1;
               default: beat.frame_length = 11'($urandom());
            endcase
            {beat.deferred, beat.carrier_lost, beat.underrun, beat.retry_limit,
             beat.late_collision, beat.heartbeat_lost} =
               ($urandom_range(0, 3) == 0) ? 6'd0 : 6'($urandom());
            beat.counter_select = ($urandom_range(0, 9) == 0) ?
                                  4'($urandom_range(NUM_COUNTERS, 15)) :
                                  4'($urandom_range(0, NUM_COUNTERS - 1));
            send_beat(beat, 1'b0, '0);
            burst--;
            left--;
         end
         if (bursty) begin
            idle_cycles(($urandom_range(0, 9) == 0) ? $urandom_range(10, 24) :
                        $urandom_range(0, 4));
         end
         if ($urandom_range(0, 39) == 0) drain();
      end
   endtask

   // Result side: check each beat against the oldest expectation, then choose
   // the next ready from a rotating pattern with one long hold-off.
   always @(posedge clock) begin
      rsp_type     want;
      int unsigned mode;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            beats_checked++;
            if (pending_responses.size() == 0) begin
               $error("response beat with no expectation waiting");
               mismatches++;
            end else begin
               want = pending_responses.pop_front();
               if (rsp_data.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_data.status);
                  mismatches++;
               end
               if (rsp_data.reclaimed_count !== want.reclaimed_count) begin
                  $error("reclaimed_count: expected %0d, got %0d",
                         want.reclaimed_count, rsp_data.reclaimed_count);
                  mismatches++;
               end
               if (rsp_data.ring_full !== want.ring_full) begin
                  $error("ring_full: expected %0d, got %0d",
                         want.ring_full, rsp_data.ring_full);
                  mismatches++;
               end
               if (rsp_data.transmitter_busy !== want.transmitter_busy) begin
                  $error("transmitter_busy: expected %0d, got %0d",
                         want.transmitter_busy, rsp_data.transmitter_busy);
                  mismatches++;
               end
               if (rsp_data.in_flight !== want.in_flight) begin
                  $error("in_flight: expected %0d, got %0d",
                         want.in_flight, rsp_data.in_flight);
                  mismatches++;
               end
               if (rsp_data.counter_value !== want.counter_value) begin
                  $error("counter_value: expected %0d, got %0d",
                         want.counter_value, rsp_data.counter_value);
                  mismatches++;
               end
            end
         end
         rx_cycles++;
         mode = (rx_cycles / 256) % 4;
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (!long_hold_done && beats_checked >= 300) begin
            // One long hold-off so the output register fills and the input stalls.
            long_hold_done = 1'b1;
            hold_left      = HOLD_CYCLES;
            rsp_ready     <= 1'b0;
         end else begin
            case (mode)
               0:       rsp_ready <= 1'b1;
               1:       rsp_ready <= (rx_cycles % 4) != 3;
               2:       rsp_ready <= $urandom_range(0, 1);
               default: rsp_ready <= ($urandom_range(0, 4) == 0);
            endcase
         end
      end
   end

   // Stimulus and the end of the run.
   initial begin
      int unsigned      i;
      logic [15:0]      phase_timeout [6];
      bit               phase_bursty [6];

      // Predicted reset state.
      for (i = 0; i < RING; i++) begin
         desc_owned[i] = 1'b0;
         desc_flags[i] = '0;
      end
      for (i = 0; i < NUM_COUNTERS; i++) stats[i] = '0;
      head_idx        = 0;
      tail_idx        = 0;
      hw_idx          = 0;
      ring_full_q     = 1'b0;
      tx_busy_q       = 1'b0;
      ticks_q         = '0;
      timeout_setting = TIMEOUT_RESET;

      // Directed table: empty ring, fill to full, busy retry, timeout, full refusal,
      // completions with each flag, full-ring reclaim and a reclaim that stops early.
      add_row(0, 0, make_beat(ACT_TICK, 0, 6'h00, C_PACKETS), 1,
              make_rsp(ST_ACCEPTED, 0, 0, 0, 0, 0));
      add_row(0, 0, make_beat(ACT_COMPLETE, 0, 6'h3F, 4'd15), 1,
              make_rsp(ST_DONE, 0, 0, 0, 0, 0));
      add_row(0, 0, make_beat(ACT_RECLAIM, 0, 6'h00, C_PACKETS), 1,
              make_rsp(ST_DONE, 0, 0, 0, 0, 0));
      add_row(0, 0, make_beat(ACT_SUBMIT, 11'd2047, 6'h00, C_BYTES), 1,
              make_rsp(ST_ACCEPTED, 0, 0, 0, 1, 2047));
      add_row(0, 0, make_beat(ACT_SUBMIT, 11'd0, 6'h00, C_BYTES), 1,
              make_rsp(ST_ACCEPTED, 0, 0, 0, 2, 2047));
      add_row(0, 0, make_beat(ACT_SUBMIT, 11'd64, 6'h00, C_BYTES), 0, '0);
      add_row(0, 0, make_beat(ACT_SUBMIT, 11'd1500, 6'h00, C_BYTES), 0, '0);
      add_row(0, 0, make_beat(ACT_SUBMIT, 11'd1, 6'h00, C_BYTES), 0, '0);
      add_row(0, 0, make_beat(ACT_SUBMIT, 11'd1024, 6'h00, C_BYTES), 0, '0);
      add_row(0, 0, make_beat(ACT_SUBMIT, 11'd512, 6'h00, C_BYTES), 0, '0);
      add_row(0, 0, make_beat(ACT_SUBMIT, 11'd60, 6'h00, C_BYTES), 0, '0);
      add_row(0, 0, make_beat(ACT_SUBMIT, 11'd99, 6'h00, C_PACKETS), 1,
              make_rsp(ST_BUSY, 0, 1, 1, 8, 0));
      add_row(1, 16'd1, make_beat(ACT_TICK, 0, 6'h00, C_ERRORS), 0, '0);
      add_row(0, 0, make_beat(ACT_SUBMIT, 11'd99, 6'h00, C_ERRORS), 1,
              make_rsp(ST_TIMED_OUT, 0, 1, 0, 8, 1));
      add_row(0, 0, make_beat(ACT_SUBMIT, 11'd99, 6'h00, C_ERRORS), 1,
              make_rsp(ST_RING_FULL, 0, 1, 1, 8, 1));
      add_row(0, 0, make_beat(ACT_COMPLETE, 0, 6'h3F, C_HEARTBEAT), 0, '0);
      add_row(0, 0, make_beat(ACT_COMPLETE, 0, 6'h01, C_HEARTBEAT), 0, '0);
      add_row(0, 0, make_beat(ACT_COMPLETE, 0, 6'h02, C_WINDOW), 0, '0);
      add_row(0, 0, make_beat(ACT_COMPLETE, 0, 6'h04, C_ABORTED), 0, '0);
      add_row(0, 0, make_beat(ACT_COMPLETE, 0, 6'h08, C_FIFO), 0, '0);
      add_row(0, 0, make_beat(ACT_COMPLETE, 0, 6'h10, C_CARRIER), 0, '0);
      add_row(0, 0, make_beat(ACT_COMPLETE, 0, 6'h20, C_COLLISIONS), 0, '0);
      add_row(0, 0, make_beat(ACT_COMPLETE, 0, 6'h00, C_ERRORS), 0, '0);
      add_row(0, 0, make_beat(ACT_RECLAIM, 0, 6'h00, C_PACKETS), 1,
              make_rsp(ST_DONE, 8, 0, 0, 0, 8));
      add_row(0, 0, make_beat(ACT_SUBMIT, 11'd100, 6'h00, C_ERRORS), 0, '0);
      add_row(0, 0, make_beat(ACT_SUBMIT, 11'd200, 6'h00, C_COLLISIONS), 0, '0);
      add_row(0, 0, make_beat(ACT_COMPLETE, 0, 6'h20, C_COLLISIONS), 0, '0);
      add_row(0, 0, make_beat(ACT_RECLAIM, 0, 6'h00, C_COLLISIONS), 0, '0);
      add_row(0, 0, make_beat(ACT_RECLAIM, 0, 6'h00, 4'd9), 0, '0);

      // Timeout settings for the random phases, the extremes among them.
      phase_timeout[0] = 16'd1;
      phase_timeout[1] = 16'hFFFF;
      phase_timeout[2] = 16'($urandom_range(2, 40));
      phase_timeout[3] = 16'($urandom_range(1, 65535));
      phase_timeout[4] = TIMEOUT_RESET;
      phase_timeout[5] = 16'd5;
      phase_bursty     = '{1, 0, 1, 1, 1, 0};

      // Hold the synchronous reset, then release it.
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[r]) begin
         if (directed_rows[r].csr_write) begin
            drain();
            write_timeout(directed_rows[r].csr_value);
         end
         send_beat(directed_rows[r].beat, directed_rows[r].typed, directed_rows[r].typed_rsp);
      end

      for (i = 0; i < 6; i++) begin
         drain();
         write_timeout(phase_timeout[i]);
         random_phase(200, phase_bursty[i]);
      end

      // Let the last responses come home, then a short quiet tail.
      req_valid <= 1'b0;
      while (pending_responses.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("Run covered %0d request beats and %0d checked responses under %0d timeout writes,",
               beats_sent, beats_checked, settings_used);
      $display("including %0d timeouts, %0d ring-full refusals and %0d full-ring reclaims.",
               timeouts_seen, refusals_seen, full_reclaims);
      if (mismatches == 0 && pending_responses.size() == 0) begin
         $display("tx_descriptor_ring_tracker_core regression: pass");
      end else begin
         $display("tx_descriptor_ring_tracker_core regression: fail");
      end
      $finish;
   end

endmodule
